/* hdl/oale_pkg.sv */
// ----------------------------------------------------------------------------
// oale_pkg - ordered array list engine package
// Sizes, operation and status codes, and the per-cell control type.
// ----------------------------------------------------------------------------
package oale_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = 10;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STAT_W   = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_TAKE_LOWER = 2'd2,
        CELL_TAKE_UPPER = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

/* hdl/oale_cell.sv */
// ----------------------------------------------------------------------------
// oale_cell - one list entry
// Holds one word; loads a new word, takes a neighbor's word, or holds, and
// compares its word against the search value.
// ----------------------------------------------------------------------------
module oale_cell (
    input  logic                                aclk,
    input  oale_pkg::cell_ctrl_t                ctrl,
    input  logic signed [oale_pkg::WORD_W-1:0]  load_value,
    input  logic signed [oale_pkg::WORD_W-1:0]  lower_data,
    input  logic signed [oale_pkg::WORD_W-1:0]  upper_data,
    output logic signed [oale_pkg::WORD_W-1:0]  entry_data,
    output logic                                match
);

    logic signed [oale_pkg::WORD_W-1:0] entry_reg;
    logic signed [oale_pkg::WORD_W-1:0] entry_next;

    always_comb begin
        case (ctrl.op)
            oale_pkg::CELL_LOAD:       entry_next = load_value;
            oale_pkg::CELL_TAKE_LOWER: entry_next = lower_data;
            oale_pkg::CELL_TAKE_UPPER: entry_next = upper_data;
            default:                   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_data = entry_reg;
    assign match      = (entry_reg == load_value);

endmodule

/* hdl/ordered_array_list_engine_core.sv */
// ----------------------------------------------------------------------------
// ordered_array_list_engine_core - ordered list of signed words in a cell row
// Insert, delete, read, find, overwrite and clear on a 1-based list.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: func, position and value.
//   m_axis returns exactly one result per operation: status, data_out,
//   found_position and list_length (length after the operation).
//   Each operation is decoded and applied in the cycle it is accepted; the
//   result appears in the output register on the next cycle, and
//   throughput is one operation per cycle unless the receiver stalls.
//   The row of cells shifts all entries up or down in one step and
//   compares all of them against the search value at once; the
//   first-match encoder and the read mux over the row set the cycle time.
//   When the receiver stalls, the result holds in the output register and
//   s_axis_tready stays low until it is taken; a new operation is accepted
//   in the same cycle that the pending result is taken.
//   Reset clears the length and the output valid; entry contents are not
//   cleared and are only read after being written.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [2:0] func, [7:3] position, [39:8] value
    input  logic [oale_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [2:0] status, [34:3] data_out, [39:35] found_position,
    // [44:40] list_length, [47:45] zero
    output logic [oale_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int CAP = oale_pkg::CAPACITY;

    logic [oale_pkg::FUNC_W-1:0]        in_func;
    logic [oale_pkg::POS_W-1:0]         in_pos;
    logic signed [oale_pkg::WORD_W-1:0] in_value;

    logic [oale_pkg::CNT_W-1:0] count_reg;
    logic [oale_pkg::CNT_W-1:0] count_next;

    logic                               m_valid_reg;
    logic [oale_pkg::STAT_W-1:0]        status_reg,  status_next;
    logic signed [oale_pkg::WORD_W-1:0] data_reg,    data_next;
    logic [oale_pkg::POS_W-1:0]         found_reg,   found_next;

    oale_pkg::cell_ctrl_t               cell_ctrl  [CAP];
    logic signed [oale_pkg::WORD_W-1:0] cell_data  [CAP];
    logic signed [oale_pkg::WORD_W-1:0] cell_lower [CAP];
    logic signed [oale_pkg::WORD_W-1:0] cell_upper [CAP];
    logic [CAP-1:0]                     cell_match;

    logic                           accept;
    logic [oale_pkg::CMP_W-1:0]     pos_ext;
    logic [oale_pkg::CMP_W-1:0]     cnt_ext;
    logic [oale_pkg::CMP_W-1:0]     pos_m1;
    logic [oale_pkg::IDX_W-1:0]     sel_idx;
    logic                           pos_ok;
    logic                           pos_ok_ins;
    logic                           is_full;
    logic                           do_insert;
    logic                           do_delete;
    logic                           do_modify;
    logic signed [oale_pkg::WORD_W-1:0] sel_data;
    logic [oale_pkg::POS_W-1:0]     first_pos;
    logic                           any_match;

    assign in_func  = s_axis_tdata[2:0];
    assign in_pos   = s_axis_tdata[7:3];
    assign in_value = s_axis_tdata[39:8];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pos_ext    = oale_pkg::CMP_W'(in_pos);
    assign cnt_ext    = oale_pkg::CMP_W'(count_reg);
    assign pos_m1     = pos_ext - oale_pkg::CMP_W'(1);
    assign sel_idx    = pos_m1[oale_pkg::IDX_W-1:0];
    assign pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + oale_pkg::CMP_W'(1));
    assign is_full    = (cnt_ext >= oale_pkg::CMP_W'(CAP));
    assign sel_data   = cell_data[sel_idx];

    assign do_insert = accept && (in_func == oale_pkg::FUNC_INSERT) && pos_ok_ins && !is_full;
    assign do_delete = accept && (in_func == oale_pkg::FUNC_DELETE) && pos_ok;
    assign do_modify = accept && (in_func == oale_pkg::FUNC_MODIFY) && pos_ok;

    // First valid match; scan from the top so the lowest position wins.
    always_comb begin
        first_pos = '0;
        any_match = 1'b0;
        for (int j = CAP - 1; j >= 0; j--) begin
            if (cell_match[j] && (oale_pkg::CMP_W'(j) < cnt_ext)) begin
                first_pos = oale_pkg::POS_W'(j + 1);
                any_match = 1'b1;
            end
        end
    end

    // Cell steering: insert opens a slot, delete closes one, modify reloads one.
    always_comb begin
        for (int j = 0; j < CAP; j++) begin
            cell_ctrl[j].op = oale_pkg::CELL_HOLD;
            if (do_insert) begin
                if (oale_pkg::CMP_W'(j) == pos_m1) begin
                    cell_ctrl[j].op = oale_pkg::CELL_LOAD;
                end else if (oale_pkg::CMP_W'(j) > pos_m1) begin
                    cell_ctrl[j].op = oale_pkg::CELL_TAKE_LOWER;
                end
            end else if (do_delete) begin
                if (oale_pkg::CMP_W'(j) >= pos_m1) begin
                    cell_ctrl[j].op = oale_pkg::CELL_TAKE_UPPER;
                end
            end else if (do_modify) begin
                if (oale_pkg::CMP_W'(j) == pos_m1) begin
                    cell_ctrl[j].op = oale_pkg::CELL_LOAD;
                end
            end
        end
    end

    always_comb begin
        status_next = oale_pkg::ST_OK;
        data_next   = '0;
        found_next  = '0;
        count_next  = count_reg;
        case (in_func)
            oale_pkg::FUNC_INSERT: begin
                if (!pos_ok_ins) begin
                    status_next = oale_pkg::ST_RANGE;
                end else if (is_full) begin
                    status_next = oale_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + oale_pkg::CNT_W'(1);
                end
            end
            oale_pkg::FUNC_DELETE: begin
                if (count_reg == '0) begin
                    status_next = oale_pkg::ST_EMPTY;
                end else if (!pos_ok) begin
                    status_next = oale_pkg::ST_RANGE;
                end else begin
                    data_next  = sel_data;
                    count_next = count_reg - oale_pkg::CNT_W'(1);
                end
            end
            oale_pkg::FUNC_READ: begin
                if (!pos_ok) begin
                    status_next = oale_pkg::ST_RANGE;
                end else begin
                    data_next = sel_data;
                end
            end
            oale_pkg::FUNC_FIND: begin
                if (any_match) begin
                    found_next = first_pos;
                end else begin
                    status_next = oale_pkg::ST_NOTFOUND;
                end
            end
            oale_pkg::FUNC_MODIFY: begin
                if (!pos_ok) begin
                    status_next = oale_pkg::ST_RANGE;
                end
            end
            oale_pkg::FUNC_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign cell_lower[g] = in_value;
            end else begin : g_mid
                assign cell_lower[g] = cell_data[g-1];
            end
            if (g == CAP - 1) begin : g_last
                assign cell_upper[g] = cell_data[g];
            end else begin : g_inner
                assign cell_upper[g] = cell_data[g+1];
            end
            oale_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl[g]),
                .load_value (in_value),
                .lower_data (cell_lower[g]),
                .upper_data (cell_upper[g]),
                .entry_data (cell_data[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload needs no reset; load on accept only.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            data_reg   <= data_next;
            found_reg  <= found_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, oale_pkg::POS_W'(count_reg), found_reg, data_reg,
                            status_reg};

endmodule

/* hdl/oale_checker.sv */
// ----------------------------------------------------------------------------
// oale_checker - port-level checks for the ordered array list engine
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module oale_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [oale_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [oale_pkg::STAT_W-1:0] status;
    logic [31:0]                 data_out;
    logic [4:0]                  found_pos;
    logic [4:0]                  list_len;

    assign status    = m_axis_tdata[2:0];
    assign data_out  = m_axis_tdata[34:3];
    assign found_pos = m_axis_tdata[39:35];
    assign list_len  = m_axis_tdata[44:40];

    // Hold a stalled result until it is taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no pending result");

    a_full_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (status == oale_pkg::ST_FULL)
            |-> (list_len == 5'(oale_pkg::CAPACITY)))
        else $error("list full reported below capacity");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (status != oale_pkg::ST_OK) |-> (data_out == '0) && (found_pos == '0))
        else $error("failed operation returned data");

endmodule

bind ordered_array_list_engine_core oale_checker u_oale_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
